// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file.
// Depends on nothing; included by the checker module only.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");

// Implication whose consequent is checked in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");

`endif

// ===== src/ssg_pkg.sv =====
// Package for the spherical shell cell geometry block: payload types, constants, states.
// Depends on nothing; used by every module of the block.
package ssg_pkg;

    localparam int RADIUS_BITS = 20;
    localparam int CUBE_BITS   = 3 * RADIUS_BITS;
    localparam int AREA_BITS   = 2 * RADIUS_BITS + 4;
    localparam int INDEX_BITS  = 16;
    localparam int MAX_CELLS   = 65536;
    localparam int CNT_BITS    = $clog2(MAX_CELLS);

    localparam logic [35:0] FOUR_PI_Q32        = 36'hC90FDAA22;
    localparam logic [34:0] FOUR_THIRDS_PI_Q32 = 35'h430548E0B;

    localparam logic CFG_CORE_RADIUS = 1'b0;
    localparam logic CFG_BOX_RADIUS  = 1'b1;

    typedef struct packed {
        logic [RADIUS_BITS-1:0] radius;
        logic                   last_point;
    } in_item_t;

    typedef struct packed {
        logic [INDEX_BITS-1:0]  cell_index;
        logic [RADIUS_BITS-1:0] inner_face_radius;
        logic [RADIUS_BITS-1:0] outer_face_radius;
        logic [43:0]            inner_face_area;
        logic [44:0]            surface_area;
        logic signed [63:0]     volume;
        logic [RADIUS_BITS-1:0] center_radius;
        logic                   last_cell;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FACE,
        ST_SQ,
        ST_CUBE,
        ST_AREA,
        ST_VOL,
        ST_CBRT_SQ,
        ST_CBRT_CU,
        ST_OUT,
        ST_NEXT
    } state_t;

endpackage

// ===== src/spherical_shell_cell_geometry.sv =====
// Top level of the spherical shell cell geometry block.
// Depends on ssg_pkg; one shared 32 by 36 bit multiplier runs under a small sequencer.
//
//   channel   direction  handshake           payload
//   in        input      in_valid/in_stall   ssg_pkg::in_item_t
//   out       output     out_valid/out_stall ssg_pkg::out_item_t
//   cfg       input      cfg_we              cfg_index, cfg_data
//
// Every multiply works through the wide operand in its two 32 bit halves, one after the other.
// A cell pass runs square, cube, area and volume, then the cube root at two multiplies
// per result bit, then one step for output and one for bookkeeping.
// An item takes one pass, or two when it closes a set, and in_stall holds off the next
// input until the item is done. Reset is asynchronous and clears control state.
// A result held by out_stall stops the next pass at its output step.
module spherical_shell_cell_geometry (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  ssg_pkg::in_item_t                 in_data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output ssg_pkg::out_item_t                out_data,
    input  logic                              cfg_we,
    input  logic                              cfg_index,
    input  logic [ssg_pkg::RADIUS_BITS-1:0]   cfg_data
);

    localparam int RB = ssg_pkg::RADIUS_BITS;
    localparam int CB = ssg_pkg::CUBE_BITS;
    localparam int AB = ssg_pkg::AREA_BITS;
    localparam int BB = $clog2(RB);
    localparam int NB = ssg_pkg::CNT_BITS;

    ssg_pkg::state_t state_reg, state_next;

    logic [RB-1:0] core_reg, box_reg;
    logic [RB-1:0] prev_r_reg, prev_face_reg;
    logic [CB-1:0] prev_cube_reg;
    logic [AB-1:0] prev_area_reg;
    logic [ssg_pkg::CNT_BITS-1:0] cnt_reg;
    logic          started_reg;

    logic [RB-1:0] in_r_reg;
    logic          in_last_reg;
    logic          second_reg;

    logic [RB-1:0] ri_reg, ro_reg;
    logic [CB-1:0] ci_reg, co_reg;
    logic [AB-1:0] ai_reg, ao_reg;
    logic          vneg_reg;
    logic [CB-1:0] vmag_reg;
    logic [CB-1:0] mean_reg;
    logic [RB-1:0] y_reg, t_reg;
    logic [BB-1:0] bit_reg;
    logic [2*RB-1:0] sq_reg;
    logic          clast_reg;
    logic signed [63:0] vol_reg;
    ssg_pkg::out_item_t out_reg;
    logic          out_valid_reg;
    logic          out_load;

    // Shared multiplier: 32 x 36 bits per cycle, a 64 x 36 bit product in two halves.
    logic [63:0] mul_a;
    logic [35:0] mul_b;
    logic        mul_state;
    logic        mul_round;
    logic        half_reg;
    logic [31:0] mul_lo;
    logic [67:0] mul_q;
    logic [99:0] acc_reg;
    logic [99:0] mul_p;
    logic [63:0] scaled;

    assign mul_lo = half_reg ? mul_a[63:32] : mul_a[31:0];
    assign mul_q  = {36'd0, mul_lo} * {32'd0, mul_b};
    assign mul_p  = acc_reg + {mul_q, 32'd0};
    assign scaled = (mul_p[99:96] != 4'd0) ? {64{1'b1}} : mul_p[95:32];

    logic [RB-1:0] face_w;
    assign face_w = RB'(({1'b0, prev_r_reg} + {1'b0, in_r_reg}) >> 1);

    always_comb
    begin
        mul_a     = 64'd0;
        mul_b     = 36'd0;
        mul_state = 1'b0;
        mul_round = 1'b0;
        unique case (state_reg)
            ssg_pkg::ST_SQ:
            begin
                mul_a = 64'(ro_reg); mul_b = 36'(ro_reg); mul_state = 1'b1;
            end
            ssg_pkg::ST_CUBE:
            begin
                mul_a = 64'(sq_reg); mul_b = 36'(ro_reg); mul_state = 1'b1;
            end
            ssg_pkg::ST_AREA:
            begin
                mul_a = 64'(sq_reg); mul_b = ssg_pkg::FOUR_PI_Q32;
                mul_state = 1'b1; mul_round = 1'b1;
            end
            ssg_pkg::ST_VOL:
            begin
                mul_a = 64'(vmag_reg); mul_b = 36'(ssg_pkg::FOUR_THIRDS_PI_Q32);
                mul_state = 1'b1; mul_round = 1'b1;
            end
            ssg_pkg::ST_CBRT_SQ:
            begin
                mul_a = 64'(t_reg); mul_b = 36'(t_reg); mul_state = 1'b1;
            end
            ssg_pkg::ST_CBRT_CU:
            begin
                mul_a = 64'(sq_reg); mul_b = 36'(t_reg); mul_state = 1'b1;
            end
            default:             begin mul_a = 64'd0; mul_b = 36'd0; end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ssg_pkg::ST_IDLE:    if (in_valid) state_next = ssg_pkg::ST_FACE;
            ssg_pkg::ST_FACE:    state_next = ssg_pkg::ST_SQ;
            ssg_pkg::ST_SQ:      state_next = ssg_pkg::ST_CUBE;
            ssg_pkg::ST_CUBE:    state_next = ssg_pkg::ST_AREA;
            ssg_pkg::ST_AREA:    state_next = ssg_pkg::ST_VOL;
            ssg_pkg::ST_VOL:     state_next = ssg_pkg::ST_CBRT_SQ;
            ssg_pkg::ST_CBRT_SQ: state_next = ssg_pkg::ST_CBRT_CU;
            ssg_pkg::ST_CBRT_CU: state_next = (bit_reg == BB'(0)) ? ssg_pkg::ST_OUT
                                                                  : ssg_pkg::ST_CBRT_SQ;
            ssg_pkg::ST_OUT:     if (!out_valid_reg || !out_stall) state_next = ssg_pkg::ST_NEXT;
            ssg_pkg::ST_NEXT:    state_next = ((!second_reg && clast_reg)
                                               || (!started_reg && in_last_reg))
                                              ? ssg_pkg::ST_SQ : ssg_pkg::ST_IDLE;
            default:             state_next = ssg_pkg::ST_IDLE;
        endcase
        if (mul_state && !half_reg)
            state_next = state_reg;
    end

    assign in_stall = (state_reg != ssg_pkg::ST_IDLE);
    assign out_load = (state_reg == ssg_pkg::ST_OUT) && (!out_valid_reg || !out_stall)
                      && (!second_reg || started_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ssg_pkg::ST_IDLE;
            core_reg      <= '0;
            box_reg       <= '1;
            prev_r_reg    <= '0;
            prev_face_reg <= '0;
            prev_cube_reg <= '0;
            prev_area_reg <= '0;
            cnt_reg       <= '0;
            started_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            second_reg    <= 1'b0;
            half_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                if (cfg_index == ssg_pkg::CFG_CORE_RADIUS) core_reg <= cfg_data;
                else                                       box_reg  <= cfg_data;
            end
            if (mul_state)
            begin
                half_reg <= !half_reg;
                if (!half_reg)
                    acc_reg <= {32'd0, mul_q} + (mul_round ? 100'h80000000 : 100'd0);
            end
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                ssg_pkg::ST_IDLE:
                begin
                    in_r_reg    <= in_data.radius;
                    in_last_reg <= in_data.last_point;
                end
                ssg_pkg::ST_FACE:
                begin
                    // clast_reg marks that the set-closing cell follows this one.
                    if (!started_reg)
                    begin
                        cnt_reg    <= '0;
                        ri_reg     <= core_reg;
                        ro_reg     <= core_reg;
                        ci_reg     <= '0;
                        ai_reg     <= '0;
                        second_reg <= 1'b1;
                        clast_reg  <= 1'b0;
                    end
                    else
                    begin
                        ri_reg     <= prev_face_reg;
                        ci_reg     <= prev_cube_reg;
                        ai_reg     <= prev_area_reg;
                        ro_reg     <= face_w;
                        second_reg <= 1'b0;
                        clast_reg  <= in_last_reg;
                    end
                end
                ssg_pkg::ST_SQ:   if (half_reg) sq_reg <= mul_p[2*RB-1:0];
                ssg_pkg::ST_CUBE:
                if (half_reg)
                begin
                    co_reg <= mul_p[CB-1:0];
                    mean_reg <= CB'(({1'b0, ci_reg} + {1'b0, mul_p[CB-1:0]}) >> 1);
                    vneg_reg <= (mul_p[CB-1:0] < ci_reg);
                    vmag_reg <= (mul_p[CB-1:0] >= ci_reg) ? mul_p[CB-1:0] - ci_reg
                                                          : ci_reg - mul_p[CB-1:0];
                end
                ssg_pkg::ST_AREA:
                if (half_reg)
                begin
                    ao_reg  <= scaled[AB-1:0];
                    y_reg   <= '0;
                    bit_reg <= BB'(RB-1);
                    t_reg   <= RB'(1) << (RB-1);
                end
                ssg_pkg::ST_VOL:
                if (half_reg)
                begin
                    if (!vneg_reg)
                        vol_reg <= scaled[63] ? 64'sh7FFFFFFFFFFFFFFF : $signed(scaled);
                    else
                        vol_reg <= (scaled > 64'h8000000000000000)
                                   ? 64'sh8000000000000000 : $signed(~scaled + 64'd1);
                end
                ssg_pkg::ST_CBRT_SQ: if (half_reg) sq_reg <= mul_p[2*RB-1:0];
                ssg_pkg::ST_CBRT_CU:
                if (half_reg)
                begin
                    if (mul_p[CB-1:0] <= mean_reg)
                    begin
                        y_reg <= t_reg;
                        if (bit_reg != BB'(0)) t_reg <= t_reg | (RB'(1) << (bit_reg - BB'(1)));
                    end
                    else if (bit_reg != BB'(0))
                        t_reg <= y_reg | (RB'(1) << (bit_reg - BB'(1)));
                    bit_reg <= bit_reg - BB'(1);
                end
                ssg_pkg::ST_OUT:
                begin
                    if (out_load)
                    begin
                        out_reg.cell_index        <= ssg_pkg::INDEX_BITS'(cnt_reg);
                        out_reg.inner_face_radius <= ri_reg;
                        out_reg.outer_face_radius <= ro_reg;
                        out_reg.inner_face_area   <= ai_reg;
                        out_reg.surface_area      <= {1'b0, ai_reg} + {1'b0, ao_reg};
                        out_reg.volume            <= vol_reg;
                        out_reg.center_radius     <= y_reg;
                        out_reg.last_cell         <= second_reg;
                        cnt_reg <= cnt_reg + NB'(1);
                    end
                end
                ssg_pkg::ST_NEXT:
                begin
                    if (!second_reg && clast_reg)
                    begin
                        // Closing cell of the set: from the new face to the box radius.
                        ri_reg     <= ro_reg;
                        ci_reg     <= co_reg;
                        ai_reg     <= ao_reg;
                        ro_reg     <= box_reg;
                        second_reg <= 1'b1;
                    end
                    else if (!second_reg || !started_reg)
                    begin
                        if (!started_reg && in_last_reg)
                        begin
                            // First point is also the last: one cell from core to box.
                            ri_reg      <= ro_reg;
                            ci_reg      <= co_reg;
                            ai_reg      <= ao_reg;
                            ro_reg      <= box_reg;
                            started_reg <= 1'b1;
                            clast_reg   <= 1'b1;
                            second_reg  <= 1'b1;
                        end
                        else
                        begin
                            started_reg   <= 1'b1;
                            prev_r_reg    <= in_r_reg;
                            prev_face_reg <= ro_reg;
                            prev_cube_reg <= co_reg;
                            prev_area_reg <= ao_reg;
                        end
                    end
                    else
                    begin
                        started_reg   <= 1'b0;
                        cnt_reg       <= '0;
                        prev_r_reg    <= '0;
                        prev_face_reg <= '0;
                        prev_cube_reg <= '0;
                        prev_area_reg <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// ===== src/ssg_checker.sv =====
// Port-level checker for the spherical shell cell geometry block, with its bind.
// Depends on ssg_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ssg_port_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input ssg_pkg::out_item_t out_data
);

    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))
    `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)
    `ASSERT_IMPLY(a_out_known, clk, rst_n, out_valid, !$isunknown(out_data))

endmodule

bind spherical_shell_cell_geometry ssg_port_checker u_ssg_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
